[rtl/alle_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package alle_pkg;

   // default sizing of the stores
   localparam int DEPTH_DEF      = 1024;
   localparam int DATA_WIDTH_DEF = 32;

   // fixed port field widths
   localparam int OP_W     = 2;
   localparam int K_W      = 11;
   localparam int VALUE_W  = 32;
   localparam int STATUS_W = 2;
   localparam int SLOT_W   = 10;

   typedef enum logic [OP_W-1:0] {
      OP_INS_HEAD  = 2'd0,
      OP_DEL_AFTER = 2'd1,
      OP_INS_AFTER = 2'd2,
      OP_TAKE_HEAD = 2'd3
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK        = 2'd0,
      ST_EMPTY     = 2'd1,
      ST_FULL      = 2'd2,
      ST_BAD_INDEX = 2'd3
   } status_type;

   // store address source
   typedef enum logic [1:0] {
      ADDR_HEAD   = 2'd0,
      ADDR_ANCHOR = 2'd1,
      ADDR_RDATA  = 2'd2,
      ADDR_COUNT  = 2'd3
   } addr_sel_type;

   // next-store write data source
   typedef enum logic [1:0] {
      WD_HEAD  = 2'd0,
      WD_RDATA = 2'd1,
      WD_COUNT = 2'd2
   } wdata_sel_type;

   // result slot source
   typedef enum logic [1:0] {
      SLOT_ZERO  = 2'd0,
      SLOT_COUNT = 2'd1,
      SLOT_HEAD  = 2'd2
   } slot_sel_type;

   // controller to datapath
   typedef struct packed {
      logic          latch_req;
      logic          mem_en;
      logic          mem_we;
      logic          value_we;
      addr_sel_type  addr_sel;
      wdata_sel_type wdata_sel;
      logic          head_load;
      logic          head_from_rd;
      logic          count_inc;
      logic          res_load;
      status_type    res_status;
      logic          res_take;
      slot_sel_type  slot_sel;
      logic          out_load;
   } ctrl_cmd_type;

   // datapath to controller
   typedef struct packed {
      op_type op;
      logic   k_zero;
      logic   k_bad;
      logic   full;
      logic   head_null;
      logic   rd_null;
   } ctrl_stat_type;

endpackage

`default_nettype wire

[rtl/alle_ram.sv]
`timescale 1ns / 1ps
`default_nettype none

module alle_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     en,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] addr,
   input  wire logic [WIDTH-1:0]         wdata,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // write or read one word per cycle, read data registered
   always_ff @(posedge clock) begin
      if (en) begin
         if (we) begin
            mem_ff[addr] <= wdata;
         end else begin
            rdata_ff <= mem_ff[addr];
         end
      end
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

[rtl/alle_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none

module alle_ctrl (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_stall,
   output logic                        rsp_valid,
   input  wire logic                   rsp_stall,
   input  wire alle_pkg::ctrl_stat_type stat,
   output alle_pkg::ctrl_cmd_type      cmd
);
   import alle_pkg::*;

   typedef enum logic [6:0] {
      S_IDLE      = 7'b0000001,
      S_CHECK     = 7'b0000010,
      S_RD_HEAD   = 7'b0000100,
      S_RD_ANCHOR = 7'b0001000,
      S_RD_SUCC   = 7'b0010000,
      S_LINK      = 7'b0100000,
      S_RESP      = 7'b1000000
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   // sequence one operation through the stores
   always_comb begin
      state_in         = state_ff;
      cmd.latch_req    = 1'b0;
      cmd.mem_en       = 1'b0;
      cmd.mem_we       = 1'b0;
      cmd.value_we     = 1'b0;
      cmd.addr_sel     = ADDR_HEAD;
      cmd.wdata_sel    = WD_HEAD;
      cmd.head_load    = 1'b0;
      cmd.head_from_rd = 1'b0;
      cmd.count_inc    = 1'b0;
      cmd.res_load     = 1'b0;
      cmd.res_status   = ST_OK;
      cmd.res_take     = 1'b0;
      cmd.slot_sel     = SLOT_ZERO;
      cmd.out_load     = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.latch_req = 1'b1;
               state_in      = S_CHECK;
            end
         end
         S_CHECK: begin
            state_in = S_RESP;
            unique case (stat.op)
               OP_INS_HEAD: begin
                  cmd.res_load = 1'b1;
                  if (stat.full) begin
                     cmd.res_status = ST_FULL;
                  end else begin
                     cmd.mem_en    = 1'b1;
                     cmd.mem_we    = 1'b1;
                     cmd.value_we  = 1'b1;
                     cmd.addr_sel  = ADDR_COUNT;
                     cmd.wdata_sel = WD_HEAD;
                     cmd.head_load = 1'b1;
                     cmd.count_inc = 1'b1;
                     cmd.slot_sel  = SLOT_COUNT;
                  end
               end
               OP_DEL_AFTER: begin
                  if (stat.k_zero) begin
                     if (stat.head_null) begin
                        cmd.res_load   = 1'b1;
                        cmd.res_status = ST_EMPTY;
                     end else begin
                        cmd.mem_en   = 1'b1;
                        cmd.addr_sel = ADDR_HEAD;
                        state_in     = S_RD_HEAD;
                     end
                  end else if (stat.k_bad) begin
                     cmd.res_load   = 1'b1;
                     cmd.res_status = ST_BAD_INDEX;
                  end else begin
                     cmd.mem_en   = 1'b1;
                     cmd.addr_sel = ADDR_ANCHOR;
                     state_in     = S_RD_ANCHOR;
                  end
               end
               OP_INS_AFTER: begin
                  if (stat.k_zero || stat.k_bad) begin
                     cmd.res_load   = 1'b1;
                     cmd.res_status = ST_BAD_INDEX;
                  end else if (stat.full) begin
                     cmd.res_load   = 1'b1;
                     cmd.res_status = ST_FULL;
                  end else begin
                     cmd.mem_en   = 1'b1;
                     cmd.addr_sel = ADDR_ANCHOR;
                     state_in     = S_RD_ANCHOR;
                  end
               end
               OP_TAKE_HEAD: begin
                  if (stat.head_null) begin
                     cmd.res_load   = 1'b1;
                     cmd.res_status = ST_EMPTY;
                  end else begin
                     cmd.mem_en   = 1'b1;
                     cmd.addr_sel = ADDR_HEAD;
                     state_in     = S_RD_HEAD;
                  end
               end
               default: ;
            endcase
         end
         S_RD_HEAD: begin
            // advance the head past the old head slot
            cmd.head_load    = 1'b1;
            cmd.head_from_rd = 1'b1;
            cmd.res_load     = 1'b1;
            if (stat.op == OP_TAKE_HEAD) begin
               cmd.res_take = 1'b1;
               cmd.slot_sel = SLOT_HEAD;
            end
            state_in = S_RESP;
         end
         S_RD_ANCHOR: begin
            if (stat.op == OP_INS_AFTER) begin
               // new slot inherits the anchor's link
               cmd.mem_en    = 1'b1;
               cmd.mem_we    = 1'b1;
               cmd.value_we  = 1'b1;
               cmd.addr_sel  = ADDR_COUNT;
               cmd.wdata_sel = WD_RDATA;
               state_in      = S_LINK;
            end else if (stat.rd_null) begin
               cmd.res_load   = 1'b1;
               cmd.res_status = ST_EMPTY;
               state_in       = S_RESP;
            end else begin
               cmd.mem_en   = 1'b1;
               cmd.addr_sel = ADDR_RDATA;
               state_in     = S_RD_SUCC;
            end
         end
         S_RD_SUCC: begin
            // bypass the successor
            cmd.mem_en    = 1'b1;
            cmd.mem_we    = 1'b1;
            cmd.addr_sel  = ADDR_ANCHOR;
            cmd.wdata_sel = WD_RDATA;
            cmd.res_load  = 1'b1;
            state_in      = S_RESP;
         end
         S_LINK: begin
            // point the anchor at the new slot
            cmd.mem_en    = 1'b1;
            cmd.mem_we    = 1'b1;
            cmd.addr_sel  = ADDR_ANCHOR;
            cmd.wdata_sel = WD_COUNT;
            cmd.count_inc = 1'b1;
            cmd.res_load  = 1'b1;
            cmd.slot_sel  = SLOT_COUNT;
            state_in      = S_RESP;
         end
         S_RESP: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               cmd.out_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // hold the output word until taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

`default_nettype wire

[rtl/alle_dpath.sv]
`timescale 1ns / 1ps
`default_nettype none

module alle_dpath #(
   parameter int DEPTH      = alle_pkg::DEPTH_DEF,
   parameter int DATA_WIDTH = alle_pkg::DATA_WIDTH_DEF
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic        [alle_pkg::OP_W-1:0]    req_op,
   input  wire logic        [alle_pkg::K_W-1:0]     req_k,
   input  wire logic signed [alle_pkg::VALUE_W-1:0] req_value,
   output logic             [alle_pkg::STATUS_W-1:0] rsp_status,
   output logic signed      [alle_pkg::VALUE_W-1:0] rsp_value_out,
   output logic             [alle_pkg::SLOT_W-1:0]  rsp_slot,
   input  wire alle_pkg::ctrl_cmd_type              cmd,
   output alle_pkg::ctrl_stat_type                  stat
);
   import alle_pkg::*;

   localparam int ADDR_W = $clog2(DEPTH);
   localparam int PTR_W  = ADDR_W + 1;
   localparam int CMP_W  = (PTR_W > K_W) ? PTR_W : K_W;

   // latched request
   op_type                  op_ff;
   logic [K_W-1:0]          k_ff;
   logic [DATA_WIDTH-1:0]   value_ff;

   // list state; the all-ones pointer marks the end of the list
   logic [PTR_W-1:0]        head_ff, head_in;
   logic [PTR_W-1:0]        count_ff, count_in;

   // result and output words
   logic [STATUS_W-1:0]     res_status_ff;
   logic [VALUE_W-1:0]      res_value_ff;
   logic [SLOT_W-1:0]       res_slot_ff;
   logic [STATUS_W-1:0]     out_status_ff;
   logic [VALUE_W-1:0]      out_value_ff;
   logic [SLOT_W-1:0]       out_slot_ff;

   logic [ADDR_W-1:0]       mem_addr;
   logic [PTR_W-1:0]        next_wdata;
   logic [PTR_W-1:0]        next_rdata;
   logic [DATA_WIDTH-1:0]   value_rdata;
   logic [CMP_W-1:0]        anchor;

   assign anchor = CMP_W'(k_ff) - CMP_W'(1);

   // status back to the controller
   assign stat.op        = op_ff;
   assign stat.k_zero    = (k_ff == '0);
   assign stat.k_bad     = (CMP_W'(k_ff) > CMP_W'(count_ff));
   assign stat.full      = (count_ff == PTR_W'(DEPTH));
   assign stat.head_null = head_ff[PTR_W-1];
   assign stat.rd_null   = next_rdata[PTR_W-1];

   // select the store address
   always_comb begin
      case (cmd.addr_sel)
         ADDR_HEAD:   mem_addr = head_ff[ADDR_W-1:0];
         ADDR_ANCHOR: mem_addr = anchor[ADDR_W-1:0];
         ADDR_RDATA:  mem_addr = next_rdata[ADDR_W-1:0];
         default:     mem_addr = count_ff[ADDR_W-1:0];
      endcase
   end

   // select the link to write
   always_comb begin
      case (cmd.wdata_sel)
         WD_HEAD:  next_wdata = head_ff;
         WD_RDATA: next_wdata = next_rdata;
         default:  next_wdata = count_ff;
      endcase
   end

   alle_ram #(
      .WIDTH (PTR_W),
      .DEPTH (DEPTH)
   ) u_next_ram (
      .clock (clock),
      .en    (cmd.mem_en),
      .we    (cmd.mem_we),
      .addr  (mem_addr),
      .wdata (next_wdata),
      .rdata (next_rdata)
   );

   alle_ram #(
      .WIDTH (DATA_WIDTH),
      .DEPTH (DEPTH)
   ) u_value_ram (
      .clock (clock),
      .en    (cmd.mem_en),
      .we    (cmd.value_we),
      .addr  (mem_addr),
      .wdata (value_ff),
      .rdata (value_rdata)
   );

   // update head and fill count
   always_comb begin
      head_in  = head_ff;
      count_in = count_ff;
      if (cmd.head_load) begin
         head_in = cmd.head_from_rd ? next_rdata : count_ff;
      end
      if (cmd.count_inc) begin
         count_in = count_ff + PTR_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '1;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         count_ff <= count_in;
      end
   end

   // latch the request, capture the result, load the output word
   always_ff @(posedge clock) begin
      if (cmd.latch_req) begin
         op_ff    <= op_type'(req_op);
         k_ff     <= req_k;
         value_ff <= DATA_WIDTH'(req_value);
      end
      if (cmd.res_load) begin
         res_status_ff <= cmd.res_status;
         res_value_ff  <= cmd.res_take ? VALUE_W'(signed'(value_rdata)) : '0;
         case (cmd.slot_sel)
            SLOT_COUNT: res_slot_ff <= SLOT_W'(count_ff[ADDR_W-1:0]);
            SLOT_HEAD:  res_slot_ff <= SLOT_W'(head_ff[ADDR_W-1:0]);
            default:    res_slot_ff <= '0;
         endcase
      end
      if (cmd.out_load) begin
         out_status_ff <= res_status_ff;
         out_value_ff  <= res_value_ff;
         out_slot_ff   <= res_slot_ff;
      end
   end

   assign rsp_status    = out_status_ff;
   assign rsp_value_out = signed'(out_value_ff);
   assign rsp_slot      = out_slot_ff;

endmodule

`default_nettype wire

[rtl/array_linked_list_engine_unit.sv]
// Linked list engine over a value store and a next-slot store.
// Request channel (req_valid/req_stall): one word per operation with
// req_op, req_k and req_value. Response channel (rsp_valid/rsp_stall):
// exactly one word per request with rsp_status, rsp_value_out, rsp_slot.
// Both stores are single-port synchronous RAMs; every operation walks
// its reads and writes one RAM access per cycle:
//   insert head, errors ........ check (insert head writes its slot there), response
//   take head, delete head ..... check and read head, advance head, response
//   insert after ............... check and read anchor, write new slot, link anchor, response
//   delete after ............... check and read anchor, read and bypass successor (if any), response
// One operation is in flight at a time; a new request is taken as soon as
// the previous one has moved to the output register, even while that
// response is still stalled. A stalled response holds its word, and the
// block then waits with the next result until the output register frees.
// Reset empties the list (head at null, fill count zero) and drops any
// pending response; the stores need no clearing since no slot is read
// before it is written.
`timescale 1ns / 1ps
`default_nettype none

module array_linked_list_engine_unit #(
   parameter int DEPTH      = alle_pkg::DEPTH_DEF,
   parameter int DATA_WIDTH = alle_pkg::DATA_WIDTH_DEF
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_valid,
   output logic                                      req_stall,
   input  wire logic        [alle_pkg::OP_W-1:0]     req_op,
   input  wire logic        [alle_pkg::K_W-1:0]      req_k,
   input  wire logic signed [alle_pkg::VALUE_W-1:0]  req_value,
   output logic                                      rsp_valid,
   input  wire logic                                 rsp_stall,
   output logic             [alle_pkg::STATUS_W-1:0] rsp_status,
   output logic signed      [alle_pkg::VALUE_W-1:0]  rsp_value_out,
   output logic             [alle_pkg::SLOT_W-1:0]   rsp_slot
);
   import alle_pkg::*;

   ctrl_cmd_type  cmd;
   ctrl_stat_type stat;

   alle_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   alle_dpath #(
      .DEPTH      (DEPTH),
      .DATA_WIDTH (DATA_WIDTH)
   ) u_dpath (
      .clock         (clock),
      .reset         (reset),
      .req_op        (req_op),
      .req_k         (req_k),
      .req_value     (req_value),
      .rsp_status    (rsp_status),
      .rsp_value_out (rsp_value_out),
      .rsp_slot      (rsp_slot),
      .cmd           (cmd),
      .stat          (stat)
   );

endmodule

`default_nettype wire
